[sv/ntw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Number to word tokens package
// Shared item type, token codes and small helper functions.
// ----------------------------------------------------------------------------
package ntw_pkg;

   localparam int unsigned DigitCount = 10;
   localparam int unsigned BcdWidth   = 4 * DigitCount;
   localparam int unsigned TokWidth   = 6;
   localparam int unsigned SlotCount  = 22;

   // English token codes.
   localparam logic [TokWidth-1:0] EnHundred  = 6'd27;
   localparam logic [TokWidth-1:0] EnThousand = 6'd28;
   localparam logic [TokWidth-1:0] EnMillion  = 6'd29;
   localparam logic [TokWidth-1:0] EnBillion  = 6'd30;
   localparam logic [TokWidth-1:0] EnZero     = 6'd31;
   localparam logic [TokWidth-1:0] EnMinus    = 6'd32;
   // Russian token codes.
   localparam logic [TokWidth-1:0] RuOneFem   = 6'd36;
   localparam logic [TokWidth-1:0] RuTwoFem   = 6'd37;
   localparam logic [TokWidth-1:0] RuThousand = 6'd38;
   localparam logic [TokWidth-1:0] RuMillion  = 6'd41;
   localparam logic [TokWidth-1:0] RuBillion  = 6'd44;
   localparam logic [TokWidth-1:0] RuZero     = 6'd47;
   localparam logic [TokWidth-1:0] RuMinus    = 6'd48;
   localparam logic [TokWidth-1:0] RuOne      = 6'd0;
   localparam logic [TokWidth-1:0] RuTwo      = 6'd1;
   localparam logic [TokWidth-1:0] RuThree    = 6'd7;
   localparam logic [TokWidth-1:0] RuFour     = 6'd8;

   typedef struct packed {
      logic                lang;
      logic                neg;
      logic                zero;
      logic [BcdWidth-1:0] bcd;
   } item_type;

   // One double-dabble step: correct every digit, then shift one bit in.
   function automatic logic [BcdWidth-1:0] dabble(logic [BcdWidth-1:0] b, logic in_bit);
      logic [BcdWidth-1:0] a;
      for (int d = 0; d < DigitCount; d++) begin
         a[4*d +: 4] = (b[4*d +: 4] >= 4'd5) ? b[4*d +: 4] + 4'd3 : b[4*d +: 4];
      end
      return {a[BcdWidth-2:0], in_bit};
   endfunction

   function automatic logic [TokWidth-1:0] en_scale(logic [1:0] g);
      logic [TokWidth-1:0] t;
      unique case (g)
         2'd0:    t = EnBillion;
         2'd1:    t = EnMillion;
         default: t = EnThousand;
      endcase
      return t;
   endfunction

   function automatic logic [TokWidth-1:0] ru_scale(logic [1:0] g);
      logic [TokWidth-1:0] t;
      unique case (g)
         2'd0:    t = RuBillion;
         2'd1:    t = RuMillion;
         default: t = RuThousand;
      endcase
      return t;
   endfunction

   function automatic logic [TokWidth-1:0] ru_digit(logic [3:0] u, logic fem);
      logic [TokWidth-1:0] t;
      unique case (u)
         4'd1:    t = fem ? RuOneFem : RuOne;
         4'd2:    t = fem ? RuTwoFem : RuTwo;
         4'd3:    t = RuThree;
         4'd4:    t = RuFour;
         default: t = {2'b00, u} - 6'd3;
      endcase
      return t;
   endfunction

endpackage

[sv/number_to_word_tokens_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Number to word tokens
// Spells a signed 32-bit integer as a run of English or Russian word tokens.
// ----------------------------------------------------------------------------
// Usage: present a number on req_value with start high; it is taken at a
// rising edge where busy is low. The words come out on rsp_word, one per
// cycle while rsp_valid is high, with rsp_last marking the final word of
// the number. Between one and seventeen words are produced per number.
// The output side cannot stall: every word is shown for exactly one cycle.
// csr_we with csr_wdata writes the language bit (0 English, 1 Russian); the
// setting is captured with each number when it is taken.
// The front end converts the magnitude to decimal two bits a cycle, then
// pushes the number into the queue once the queue has room; the back end
// loads it from the queue once the previous number's last word is out.
// The front end takes no new number while converting one or waiting for
// queue room; the emitter puts out one word per cycle while it has words,
// and the queue absorbs short bursts of long numbers.
// Reset clears the converter, the queue and the emitter and sets English.
// ----------------------------------------------------------------------------
module number_to_word_tokens_top #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   output logic [5:0]  rsp_word,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_wdata
);

   logic              language_ff, language_in;
   logic              q_full, q_push, q_pop, q_valid;
   ntw_pkg::item_type q_item, q_head;

   // Language register; user must only write it while idle; not enforced.
   assign language_in = csr_we ? csr_wdata : language_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         language_ff <= 1'b0;
      end else begin
         language_ff <= language_in;
      end
   end

   // Front end: sign, magnitude and binary to decimal conversion.
   ntw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_value (req_value),
      .language  (language_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_item)
   );

   // Queue lets conversion of the next number overlap emission of this one.
   ntw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   // Back end: expands digits into word slots and emits them in order.
   ntw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_last  (rsp_last)
   );

endmodule

[sv/ntw_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Number to word tokens front end
// Takes the magnitude and converts it to ten decimal digits, two bits a cycle.
// ----------------------------------------------------------------------------
module ntw_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [31:0]       req_value,
   input  logic              language,
   input  logic              q_full,
   output logic              q_push,
   output ntw_pkg::item_type q_item
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_PUSH = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [3:0]                    cnt_ff, cnt_in;
   logic [31:0]                   mag_ff, mag_in;
   logic [ntw_pkg::BcdWidth-1:0]  bcd_ff, bcd_in;
   logic                          lang_ff, lang_in;
   logic                          neg_ff, neg_in;
   logic                          zero_ff, zero_in;
   logic                          accept;
   logic [31:0]                   mag_new;

   assign busy    = !((state_ff == ST_IDLE) || ((state_ff == ST_PUSH) && !q_full));
   assign accept  = start && !busy;
   assign mag_new = req_value[31] ? (32'd0 - req_value) : req_value;
   assign q_push  = (state_ff == ST_PUSH) && !q_full;
   assign q_item  = '{lang: lang_ff, neg: neg_ff, zero: zero_ff, bcd: bcd_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      lang_in  = lang_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_CONV: begin
            bcd_in = ntw_pkg::dabble(ntw_pkg::dabble(bcd_ff, mag_ff[31]), mag_ff[30]);
            mag_in = {mag_ff[29:0], 2'b00};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!q_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (accept) begin
         state_in = ST_CONV;
         cnt_in   = 4'd0;
         mag_in   = mag_new;
         bcd_in   = '0;
         lang_in  = language;
         neg_in   = req_value[31];
         zero_in  = (req_value == 32'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      lang_ff <= lang_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

endmodule

[sv/ntw_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Number to word tokens queue
// Small first-in first-out buffer between the converter and the token emitter.
// ----------------------------------------------------------------------------
module ntw_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ntw_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output ntw_pkg::item_type head
);

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);

   ntw_pkg::item_type   mem [DEPTH];
   logic [PtrWidth-1:0] wr_ff, wr_in;
   logic [PtrWidth-1:0] rd_ff, rd_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == CntWidth'(DEPTH));
   assign valid = (cnt_ff != '0);
   assign head  = mem[rd_ff];

   always_comb begin
      wr_in  = push ? ((wr_ff == LastPtr) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? ((rd_ff == LastPtr) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> valid)
      else $error("queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntWidth'(DEPTH))
      else $error("queue count out of range");

endmodule

[sv/ntw_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Number to word tokens back end
// Expands one converted number into token slots and emits one word a cycle.
// ----------------------------------------------------------------------------
module ntw_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  ntw_pkg::item_type              q_head,
   output logic                           q_pop,
   output logic                           rsp_valid,
   output logic [ntw_pkg::TokWidth-1:0]   rsp_word,
   output logic                           rsp_last
);

   localparam int unsigned NSlot = ntw_pkg::SlotCount;

   logic [NSlot-1:0]             mask_ff, mask_in;
   logic [ntw_pkg::TokWidth-1:0] tok_ff [NSlot];
   logic [ntw_pkg::TokWidth-1:0] tok_in [NSlot];
   logic [NSlot-1:0]             slot_ok;
   logic [NSlot-1:0]             low_bit;
   logic [NSlot-1:0]             rest;
   logic [4:0]                   sel;

   // Slots: sign, zero, then per group hundreds digit, hundred word,
   // tens or teen, unit, scale word.
   always_comb begin
      logic [3:0] h, t, u, ld;
      logic       ru, nz;
      logic [1:0] form;
      logic [ntw_pkg::BcdWidth+7:0] digits;
      int         b;
      ru = q_head.lang;
      // Two zero digits on top give the billions group a hundreds and a tens digit.
      digits = {8'd0, q_head.bcd};
      slot_ok = '0;
      for (int s = 0; s < NSlot; s++) begin
         tok_in[s] = '0;
      end
      slot_ok[0] = q_head.neg;
      tok_in[0]  = ru ? ntw_pkg::RuMinus : ntw_pkg::EnMinus;
      slot_ok[1] = q_head.zero;
      tok_in[1]  = ru ? ntw_pkg::RuZero : ntw_pkg::EnZero;
      for (int g = 0; g < 4; g++) begin
         b  = 2 + 5 * g;
         h  = digits[4*(12-3*g)-1 -: 4];
         t  = digits[4*(11-3*g)-1 -: 4];
         u  = digits[4*(10-3*g)-1 -: 4];
         nz = (h != 4'd0) || (t != 4'd0) || (u != 4'd0);
         ld = (t == 4'd1) ? 4'd0 : u;
         if (ld == 4'd1) begin
            form = 2'd0;
         end else if (ld >= 4'd2 && ld <= 4'd4) begin
            form = 2'd1;
         end else begin
            form = 2'd2;
         end
         slot_ok[b]   = (h != 4'd0);
         tok_in[b]    = ru ? ({2'b00, h} + 6'd26) : ({2'b00, h} - 6'd1);
         slot_ok[b+1] = (h != 4'd0) && !ru;
         tok_in[b+1]  = ntw_pkg::EnHundred;
         slot_ok[b+2] = (t != 4'd0);
         tok_in[b+2]  = (t == 4'd1) ? ({2'b00, u} + 6'd9) : ({2'b00, t} + 6'd17);
         slot_ok[b+3] = (t != 4'd1) && (u != 4'd0);
         tok_in[b+3]  = ru ? ntw_pkg::ru_digit(u, g == 2) : ({2'b00, u} - 6'd1);
         slot_ok[b+4] = nz && (g != 3);
         tok_in[b+4]  = ru ? (ntw_pkg::ru_scale(2'(g)) + {4'b0000, form})
                           : ntw_pkg::en_scale(2'(g));
      end
   end

   assign low_bit   = mask_ff & (~mask_ff + 1'b1);
   assign rest      = mask_ff & ~low_bit;
   assign rsp_valid = (mask_ff != '0);
   assign rsp_last  = rsp_valid && (rest == '0);
   assign q_pop     = q_valid && (rest == '0);
   assign mask_in   = q_pop ? slot_ok : rest;

   always_comb begin
      sel = '0;
      for (int s = NSlot - 1; s >= 0; s--) begin
         if (mask_ff[s]) begin
            sel = 5'(s);
         end
      end
   end

   assign rsp_word = tok_ff[sel];

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         tok_ff <= tok_in;
      end
   end

   a_pop_at_end: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (rest == '0))
      else $error("new number loaded while words remain");
   a_last_once: assert property (@(posedge clock) disable iff (reset)
      (rsp_last && !q_pop) |=> !rsp_valid)
      else $error("word emitted after last without a new number");
   a_load_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid)
      else $error("loaded number produced no words");

endmodule
